FILE: hw/rtl/aclm_pkg.sv
package aclm_pkg;

  localparam int unsigned SampleW      = 16;
  localparam int unsigned MagW         = 17;
  localparam int unsigned SquareW      = 31;
  localparam int unsigned SquareSumW   = 43;
  localparam int unsigned MagSumW      = 28;
  localparam int unsigned LevelW       = 16;
  localparam int unsigned CountW       = 13;
  localparam int unsigned ChanW        = 5;
  localparam int unsigned ChanCfgW     = 6;
  localparam int unsigned ClipW        = 16;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned RadicandW    = 44;
  localparam int unsigned RootW        = RadicandW / 2;
  localparam int unsigned SqrtRemW     = RootW + 1;
  localparam int unsigned StepW        = 6;

  localparam int unsigned MaxChannels    = 32;
  localparam int unsigned MaxFrameLength = 4096;

  localparam logic [CountW-1:0]   FrameLengthRst  = CountW'(256);
  localparam logic [ChanCfgW-1:0] ChannelCountRst = ChanCfgW'(32);
  localparam logic [ClipW-1:0]    ClipLimitRst    = ClipW'(32767);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_LENGTH  = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_CLIP_LIMIT    = 2'd2
  } cfg_reg_e;

endpackage

FILE: hw/rtl/audio_channel_level_meter_core.sv
// A sample that does not end a channel passes through accept and accumulate.
// A channel's final sample goes through accumulate, two 43-step passes of
// the shared restoring divider, 22 square-root steps and an output load.
// The input is stalled throughout; a new word is taken once the state returns.
// Reset (rst_ni low, asynchronous): state and configuration registers back to their reset values,
// accumulators and counters cleared, no output word valid.
module audio_channel_level_meter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [aclm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [aclm_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [aclm_pkg::SampleW-1:0]  sample_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [aclm_pkg::ChanW-1:0]           chan_id_o,
  output logic [aclm_pkg::LevelW-1:0]          rms_level_o,
  output logic [aclm_pkg::LevelW-1:0]          mean_magnitude_o,
  output logic [aclm_pkg::LevelW-1:0]          peak_magnitude_o,
  output logic [aclm_pkg::CountW-1:0]          clip_count_o,
  output logic                                 last_channel_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [aclm_pkg::CountW-1:0]   chan_len_q;
  logic [aclm_pkg::ChanCfgW-1:0] channel_count_q;
  logic [aclm_pkg::ClipW-1:0]    clip_limit_q;

  // accumulators
  logic [aclm_pkg::SquareSumW-1:0] square_sum_q;
  logic [aclm_pkg::MagSumW-1:0]    magnitude_sum_q;
  logic [aclm_pkg::MagW-1:0]       peak_q;
  logic [aclm_pkg::CountW-1:0]     clipped_q;
  logic [aclm_pkg::CountW-1:0]     sample_cnt_q;
  logic [aclm_pkg::ChanW-1:0]      channel_cnt_q;

  // per-word capture
  logic [aclm_pkg::MagW-1:0]    mag_q;
  logic [aclm_pkg::SquareW-1:0] square_q;
  logic                         frame_start_q;

  // result hold
  logic [aclm_pkg::ChanW-1:0]   res_chan_q;
  logic [aclm_pkg::MagW-1:0]    res_peak_q;
  logic [aclm_pkg::CountW-1:0]  res_clip_q;
  logic                         res_last_q;
  logic [aclm_pkg::LevelW-1:0]  res_mean_q;
  logic [aclm_pkg::MagSumW-1:0] div_hold_q;

  // divider / square root
  logic [aclm_pkg::SquareSumW-1:0] quo_q;
  logic [aclm_pkg::CountW-1:0]     rem_q;
  logic                            div_pass_q;
  logic [aclm_pkg::StepW-1:0]      step_q;
  logic [aclm_pkg::RadicandW-1:0]  rad_q;
  logic [aclm_pkg::RootW-1:0]      root_q;
  logic [aclm_pkg::SqrtRemW-1:0]   srem_q;

  logic                         out_valid_q;
  logic [aclm_pkg::ChanW-1:0]   out_chan_q;
  logic [aclm_pkg::LevelW-1:0]  out_rms_q;
  logic [aclm_pkg::LevelW-1:0]  out_mean_q;
  logic [aclm_pkg::LevelW-1:0]  out_peak_q;
  logic [aclm_pkg::CountW-1:0]  out_clip_q;
  logic                         out_last_q;

  logic                         in_accept;
  logic                         out_free;
  logic [aclm_pkg::MagW-1:0]    mag_d;
  logic [2*aclm_pkg::MagW-1:0]  product;
  logic [aclm_pkg::CountW-1:0]  chan_len_eff;
  logic [aclm_pkg::ChanCfgW-1:0] chan_cnt_eff;

  logic [aclm_pkg::SquareSumW-1:0] square_sum_d;
  logic [aclm_pkg::MagSumW-1:0]    magnitude_sum_d;
  logic [aclm_pkg::MagW-1:0]       peak_d;
  logic [aclm_pkg::CountW-1:0]     clipped_d;
  logic [aclm_pkg::CountW-1:0]     sample_cnt_d;
  logic [aclm_pkg::ChanW-1:0]      chan_base;
  logic                            chan_done;
  logic                            last_d;

  logic [aclm_pkg::CountW:0]       div_trial;
  logic                            div_ge;
  logic [aclm_pkg::CountW-1:0]     rem_d;
  logic [aclm_pkg::SquareSumW-1:0] quo_d;

  logic [aclm_pkg::SqrtRemW+1:0]   sqrt_cur;
  logic [aclm_pkg::SqrtRemW+1:0]   sqrt_trial;
  logic                            sqrt_ge;
  logic [aclm_pkg::SqrtRemW+1:0]   sqrt_diff;
  logic [aclm_pkg::SqrtRemW-1:0]   srem_d;
  logic [aclm_pkg::RootW-1:0]      root_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    mag_d   = sample_i[aclm_pkg::SampleW-1]
            ? aclm_pkg::MagW'(-{sample_i[aclm_pkg::SampleW-1], sample_i})
            : {1'b0, sample_i};
    product = mag_d * mag_d;
  end

  always_comb begin
    if (chan_len_q == '0) begin
      chan_len_eff = aclm_pkg::CountW'(1);
    end else if (chan_len_q > aclm_pkg::CountW'(aclm_pkg::MaxFrameLength)) begin
      chan_len_eff = aclm_pkg::CountW'(aclm_pkg::MaxFrameLength);
    end else begin
      chan_len_eff = chan_len_q;
    end
    if (channel_count_q == '0) begin
      chan_cnt_eff = aclm_pkg::ChanCfgW'(1);
    end else if (channel_count_q > aclm_pkg::ChanCfgW'(aclm_pkg::MaxChannels)) begin
      chan_cnt_eff = aclm_pkg::ChanCfgW'(aclm_pkg::MaxChannels);
    end else begin
      chan_cnt_eff = channel_count_q;
    end
  end

  // accumulate step; frame start clears before the word is added
  always_comb begin
    square_sum_d    = (frame_start_q ? '0 : square_sum_q)
                    + aclm_pkg::SquareSumW'(square_q);
    magnitude_sum_d = (frame_start_q ? '0 : magnitude_sum_q)
                    + aclm_pkg::MagSumW'(mag_q);
    peak_d          = frame_start_q ? '0 : peak_q;
    if (mag_q > peak_d) begin
      peak_d = mag_q;
    end
    clipped_d       = frame_start_q ? '0 : clipped_q;
    if (mag_q >= {1'b0, clip_limit_q}) begin
      clipped_d = clipped_d + aclm_pkg::CountW'(1);
    end
    sample_cnt_d    = (frame_start_q ? '0 : sample_cnt_q) + aclm_pkg::CountW'(1);
    chan_base       = frame_start_q ? '0 : channel_cnt_q;
    chan_done       = (sample_cnt_d >= chan_len_eff);
    last_d          = ({1'b0, chan_base} + aclm_pkg::ChanCfgW'(1)) >= chan_cnt_eff;
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    div_trial = {rem_q, quo_q[aclm_pkg::SquareSumW-1]};
    div_ge    = (div_trial >= {1'b0, chan_len_eff});
    rem_d     = div_ge ? aclm_pkg::CountW'(div_trial - {1'b0, chan_len_eff})
                       : div_trial[aclm_pkg::CountW-1:0];
    quo_d     = {quo_q[aclm_pkg::SquareSumW-2:0], div_ge};
  end

  // digit-by-digit square root, one root bit per cycle
  always_comb begin
    sqrt_cur   = {srem_q, rad_q[aclm_pkg::RadicandW-1 -: 2]};
    sqrt_trial = {1'b0, root_q, 2'b01};
    sqrt_ge    = (sqrt_cur >= sqrt_trial);
    sqrt_diff  = sqrt_cur - sqrt_trial;
    srem_d     = sqrt_ge ? sqrt_diff[aclm_pkg::SqrtRemW-1:0]
                         : sqrt_cur[aclm_pkg::SqrtRemW-1:0];
    root_d     = {root_q[aclm_pkg::RootW-2:0], sqrt_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      chan_len_q      <= aclm_pkg::FrameLengthRst;
      channel_count_q <= aclm_pkg::ChannelCountRst;
      clip_limit_q    <= aclm_pkg::ClipLimitRst;
      square_sum_q    <= '0;
      magnitude_sum_q <= '0;
      peak_q          <= '0;
      clipped_q       <= '0;
      sample_cnt_q    <= '0;
      channel_cnt_q   <= '0;
      div_pass_q      <= 1'b0;
      step_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          aclm_pkg::REG_FRAME_LENGTH:  chan_len_q      <= cfg_data_i[aclm_pkg::CountW-1:0];
          aclm_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[aclm_pkg::ChanCfgW-1:0];
          aclm_pkg::REG_CLIP_LIMIT:    clip_limit_q    <= cfg_data_i[aclm_pkg::ClipW-1:0];
          default: ;
        endcase
      end

      // in ST_DONE the output load below takes over
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            mag_q         <= mag_d;
            square_q      <= product[aclm_pkg::SquareW-1:0];
            frame_start_q <= frame_start_i;
            state_q       <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (chan_done) begin
            res_chan_q      <= chan_base;
            res_peak_q      <= peak_d;
            res_clip_q      <= clipped_d;
            res_last_q      <= last_d;
            div_hold_q      <= magnitude_sum_d;
            quo_q           <= square_sum_d;
            rem_q           <= '0;
            div_pass_q      <= 1'b0;
            step_q          <= '0;
            square_sum_q    <= '0;
            magnitude_sum_q <= '0;
            peak_q          <= '0;
            clipped_q       <= '0;
            sample_cnt_q    <= '0;
            channel_cnt_q   <= last_d ? '0 : chan_base + aclm_pkg::ChanW'(1);
            state_q         <= ST_DIV;
          end else begin
            square_sum_q    <= square_sum_d;
            magnitude_sum_q <= magnitude_sum_d;
            peak_q          <= peak_d;
            clipped_q       <= clipped_d;
            sample_cnt_q    <= sample_cnt_d;
            channel_cnt_q   <= chan_base;
            state_q         <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (step_q == aclm_pkg::StepW'(aclm_pkg::SquareSumW - 1)) begin
            step_q <= '0;
            rem_q  <= '0;
            if (!div_pass_q) begin
              rad_q      <= {1'b0, quo_d};
              quo_q      <= aclm_pkg::SquareSumW'(div_hold_q);
              div_pass_q <= 1'b1;
            end else begin
              res_mean_q <= quo_d[aclm_pkg::LevelW-1:0];
              srem_q     <= '0;
              root_q     <= '0;
              state_q    <= ST_SQRT;
            end
          end else begin
            quo_q  <= quo_d;
            rem_q  <= rem_d;
            step_q <= step_q + aclm_pkg::StepW'(1);
          end
        end
        ST_SQRT: begin
          srem_q <= srem_d;
          root_q <= root_d;
          rad_q  <= {rad_q[aclm_pkg::RadicandW-3:0], 2'b00};
          if (step_q == aclm_pkg::StepW'(aclm_pkg::RootW - 1)) begin
            step_q  <= '0;
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q + aclm_pkg::StepW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_chan_q  <= res_chan_q;
            out_rms_q   <= root_q[aclm_pkg::LevelW-1:0];
            out_mean_q  <= res_mean_q;
            out_peak_q  <= res_peak_q[aclm_pkg::LevelW-1:0];
            out_clip_q  <= res_clip_q;
            out_last_q  <= res_last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign chan_id_o        = out_chan_q;
  assign rms_level_o      = out_rms_q;
  assign mean_magnitude_o = out_mean_q;
  assign peak_magnitude_o = out_peak_q;
  assign clip_count_o     = out_clip_q;
  assign last_channel_o   = out_last_q;

endmodule

FILE: hw/rtl/aclm_checker.sv
module aclm_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  logic [aclm_pkg::ChanW-1:0]           chan_id_o,
  input  logic [aclm_pkg::LevelW-1:0]          rms_level_o,
  input  logic [aclm_pkg::LevelW-1:0]          mean_magnitude_o,
  input  logic [aclm_pkg::LevelW-1:0]          peak_magnitude_o,
  input  logic [aclm_pkg::CountW-1:0]          clip_count_o,
  input  logic                                 last_channel_o
);

  // every accepted word keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  // a new result only leaves a busy spell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without preceding work");

  // the highest channel index always closes a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (chan_id_o == {aclm_pkg::ChanW{1'b1}}) |-> last_channel_o)
    else $error("top channel not flagged last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chan_id_o)
      && $stable(rms_level_o) && $stable(mean_magnitude_o)
      && $stable(peak_magnitude_o) && $stable(clip_count_o)
      && $stable(last_channel_o))
    else $error("stalled output word changed");

endmodule

bind audio_channel_level_meter_core aclm_checker u_aclm_checker (.*);

FILE: verif/audio_channel_level_meter_core_tb.sv
`timescale 1ns / 100ps

module audio_channel_level_meter_core_tb;

  localparam logic [aclm_pkg::CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned SettleCycles = 150;

  typedef struct {
    logic [aclm_pkg::ChanW-1:0]  channel;
    logic [aclm_pkg::LevelW-1:0] rms;
    logic [aclm_pkg::LevelW-1:0] mean;
    logic [aclm_pkg::LevelW-1:0] peak;
    logic [aclm_pkg::CountW-1:0] clips;
    logic                        last;
  } chan_stats_t;

  class level_board;
    logic [aclm_pkg::CountW-1:0]     chan_len;
    logic [aclm_pkg::ChanCfgW-1:0]   chan_cfg;
    logic [aclm_pkg::ClipW-1:0]      clip_lim;
    logic [aclm_pkg::SquareSumW-1:0] sq_acc;
    logic [aclm_pkg::MagSumW-1:0]    mag_acc;
    logic [aclm_pkg::MagW-1:0]       peak_acc;
    logic [aclm_pkg::CountW-1:0]     clip_acc;
    logic [aclm_pkg::CountW-1:0]     sample_pos;
    logic [aclm_pkg::ChanW-1:0]      chan_pos;
    chan_stats_t                     pending_stats[$];
    int                              errors;
    int                              accepted;
    int                              checked;

    function new();
      chan_len   = aclm_pkg::FrameLengthRst;
      chan_cfg   = aclm_pkg::ChannelCountRst;
      clip_lim   = aclm_pkg::ClipLimitRst;
      sample_pos = '0;
      chan_pos   = '0;
      errors     = 0;
      accepted   = 0;
      checked    = 0;
      clear_acc();
    endfunction

    function void clear_acc();
      sq_acc   = '0;
      mag_acc  = '0;
      peak_acc = '0;
      clip_acc = '0;
    endfunction

    function int unsigned eff_len();
      if (chan_len == 0) return 1;
      if (chan_len > aclm_pkg::MaxFrameLength) return aclm_pkg::MaxFrameLength;
      return chan_len;
    endfunction

    function int unsigned eff_chans();
      int unsigned c;
      c = (chan_cfg == 0) ? 1 : chan_cfg;
      if (c > aclm_pkg::MaxChannels) c = aclm_pkg::MaxChannels;
      if (c > 32) c = 32;
      return c;
    endfunction

    function void write_reg(aclm_pkg::cfg_reg_e idx, logic [aclm_pkg::CfgDataW-1:0] val);
      case (idx)
        aclm_pkg::REG_FRAME_LENGTH:  chan_len = val[aclm_pkg::CountW-1:0];
        aclm_pkg::REG_CHANNEL_COUNT: chan_cfg = val[aclm_pkg::ChanCfgW-1:0];
        aclm_pkg::REG_CLIP_LIMIT:    clip_lim = val[aclm_pkg::ClipW-1:0];
        default: ;
      endcase
    endfunction

    // bitwise integer square root, one result bit per step from the top
    function logic [aclm_pkg::RootW-1:0] root_of(logic [63:0] v);
      logic [aclm_pkg::RootW-1:0] r;
      logic [63:0]                t;
      r = '0;
      for (int b = aclm_pkg::RootW - 1; b >= 0; b--) begin
        t = 64'(r | (aclm_pkg::RootW'(1) << b));
        if (t * t <= v) r = t[aclm_pkg::RootW-1:0];
      end
      return r;
    endfunction

    function void take_sample(logic signed [aclm_pkg::SampleW-1:0] s, logic fs);
      int unsigned n;
      int unsigned chans;
      logic [aclm_pkg::MagW-1:0] mag;
      chan_stats_t st;
      n = eff_len();
      chans = eff_chans();
      accepted++;
      if (fs) begin
        sample_pos = '0;
        chan_pos   = '0;
        clear_acc();
      end
      mag = s[aclm_pkg::SampleW-1] ? 17'h10000 - {1'b0, s} : {1'b0, s};
      sq_acc  = sq_acc + aclm_pkg::SquareSumW'(mag) * aclm_pkg::SquareSumW'(mag);
      mag_acc = mag_acc + aclm_pkg::MagSumW'(mag);
      if (mag > peak_acc) peak_acc = mag;
      if (32'(mag) >= 32'(clip_lim)) clip_acc = clip_acc + 1'b1;
      sample_pos = sample_pos + 1'b1;
      if (sample_pos < n) return;
      st.channel = chan_pos;
      st.rms     = aclm_pkg::LevelW'(root_of(64'(sq_acc) / 64'(n)));
      st.mean    = aclm_pkg::LevelW'(64'(mag_acc) / 64'(n));
      st.peak    = peak_acc[aclm_pkg::LevelW-1:0];
      st.clips   = clip_acc;
      st.last    = (int'(chan_pos) + 1) >= int'(chans);
      pending_stats.push_back(st);
      chan_pos   = st.last ? '0 : chan_pos + 1'b1;
      sample_pos = '0;
      clear_acc();
    endfunction

    function void check_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    function void check_stats(logic [aclm_pkg::ChanW-1:0] ch,
                              logic [aclm_pkg::LevelW-1:0] rms,
                              logic [aclm_pkg::LevelW-1:0] mean,
                              logic [aclm_pkg::LevelW-1:0] peak,
                              logic [aclm_pkg::CountW-1:0] clips, logic last);
      chan_stats_t st;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: stats word for channel %0d with none expected", $time, ch);
        return;
      end
      st = pending_stats.pop_front();
      checked++;
      check_field("chan_id", st.channel, ch);
      check_field("rms_level", st.rms, rms);
      check_field("mean_magnitude", st.mean, mean);
      check_field("peak_magnitude", st.peak, peak);
      check_field("clip_count", st.clips, clips);
      check_field("last_channel", st.last, last);
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [aclm_pkg::CfgIdxW-1:0]        cfg_index_i = '0;
  logic [aclm_pkg::CfgDataW-1:0]       cfg_data_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic signed [aclm_pkg::SampleW-1:0] sample_i = '0;
  logic                                frame_start_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [aclm_pkg::ChanW-1:0]          chan_id_o;
  logic [aclm_pkg::LevelW-1:0]         rms_level_o;
  logic [aclm_pkg::LevelW-1:0]         mean_magnitude_o;
  logic [aclm_pkg::LevelW-1:0]         peak_magnitude_o;
  logic [aclm_pkg::CountW-1:0]         clip_count_o;
  logic                                last_channel_o;

  level_board board;
  bit quiet = 1'b0;
  int burst_left = 0;
  int hold_left = 0;
  bit hold_on = 1'b0;
  int settings_seen = 0;

  audio_channel_level_meter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .frame_start_i    (frame_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .chan_id_o        (chan_id_o),
    .rms_level_o      (rms_level_o),
    .mean_magnitude_o (mean_magnitude_o),
    .peak_magnitude_o (peak_magnitude_o),
    .clip_count_o     (clip_count_o),
    .last_channel_o   (last_channel_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side: check accepted words, stall in random runs
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_stats(chan_id_o, rms_level_o, mean_magnitude_o,
                        peak_magnitude_o, clip_count_o, last_channel_o);
    end
    if (hold_left == 0) begin
      hold_left = $urandom_range(1, 12);
      hold_on = !quiet && ($urandom_range(0, 2) == 0);
    end
    hold_left--;
    out_stall_i <= hold_on;
  end

  function automatic logic signed [aclm_pkg::SampleW-1:0] pick_sample(int unsigned cl);
    int v;
    case ($urandom_range(0, 9))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3: v = $urandom_range(0, 1) ? 1 : -1;
      4: begin
        v = (cl > 32768) ? 32768 : int'(cl);
        v = v - int'($urandom_range(0, 1));
        if (v < 0) v = 0;
        if ($urandom_range(0, 1)) v = -v;
      end
      5: v = int'($urandom_range(0, 255)) - 128;
      default: v = int'($urandom & 32'hFFFF);
    endcase
    return aclm_pkg::SampleW'(v);
  endfunction

  task automatic send_word(input logic signed [aclm_pkg::SampleW-1:0] s, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(s, fs);
  endtask

  task automatic settle();
    while (board.pending_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_settings(input int unsigned fl, input int unsigned cc,
                               input int unsigned cl);
    settings_seen++;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= aclm_pkg::REG_FRAME_LENGTH;
    cfg_data_i  <= aclm_pkg::CfgDataW'(fl);
    @(posedge clk_i);
    board.write_reg(aclm_pkg::REG_FRAME_LENGTH, aclm_pkg::CfgDataW'(fl));
    cfg_index_i <= aclm_pkg::REG_CHANNEL_COUNT;
    cfg_data_i  <= aclm_pkg::CfgDataW'(cc);
    @(posedge clk_i);
    board.write_reg(aclm_pkg::REG_CHANNEL_COUNT, aclm_pkg::CfgDataW'(cc));
    cfg_index_i <= aclm_pkg::REG_CLIP_LIMIT;
    cfg_data_i  <= aclm_pkg::CfgDataW'(cl);
    @(posedge clk_i);
    board.write_reg(aclm_pkg::REG_CLIP_LIMIT, aclm_pkg::CfgDataW'(cl));
    // unmapped index, must leave the registers alone
    cfg_index_i <= RegSpare;
    cfg_data_i  <= aclm_pkg::CfgDataW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned fl, input int unsigned cc, input int unsigned cl,
                           input int count, input bit framed, input bit calm,
                           input bit full_scale);
    int unsigned frame_words;
    logic signed [aclm_pkg::SampleW-1:0] s;
    logic fs;
    quiet <= calm;
    load_settings(fl, cc, cl);
    frame_words = board.eff_len() * board.eff_chans();
    for (int i = 0; i < count; i++) begin
      s = full_scale ? 16'sh8000 : pick_sample(cl);
      if (framed)
        fs = (i % frame_words == 0) || (!full_scale && $urandom_range(0, 49) == 0);
      else
        fs = ($urandom_range(0, 63) == 0);
      send_word(s, fs);
    end
    in_valid_i <= 1'b0;
    settle();
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zeros, +-1, restart mid-channel, clip threshold edges
    load_settings(2, 3, 32767);
    send_word(32767, 1'b1);
    send_word(-32768, 1'b0);
    send_word(0, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(12345, 1'b0);
    send_word(100, 1'b1);
    send_word(-100, 1'b0);
    send_word(32766, 1'b0);
    send_word(-32767, 1'b0);
    in_valid_i <= 1'b0;
    settle();
    // zero frame length and channel count, zero clip limit
    load_settings(0, 0, 0);
    send_word(0, 1'b0);
    send_word(5, 1'b0);
    send_word(-32768, 1'b0);
    in_valid_i <= 1'b0;
    settle();
    load_settings(1, 1, 32768);
    send_word(-32768, 1'b0);
    send_word(32767, 1'b0);
    send_word(-32767, 1'b0);
    in_valid_i <= 1'b0;
    settle();

    // random; unframed phases carry partial channels over a settings change
    run_phase(0, 0, 0, 60, 1'b0, 1'b0, 1'b0);
    run_phase(1, 33, 32768, 80, 1'b0, 1'b1, 1'b0);
    run_phase(17, 3, $urandom_range(0, 65535), 120, 1'b0, 1'b0, 1'b0);
    run_phase(3, 5, 65535, 90, 1'b0, 1'b0, 1'b0);
    run_phase(2, 63, $urandom_range(0, 65535), 110, 1'b1, 1'b0, 1'b0);
    run_phase(5, 2, 20000, 120, 1'b1, 1'b0, 1'b0);
    run_phase(4, 32, $urandom_range(0, 32768), 64, 1'b1, 1'b1, 1'b0);
    // full-scale channel: largest terms in every sum
    run_phase(40, 1, 0, 40, 1'b1, 1'b0, 1'b1);

    if (board.pending_stats.size() != 0) begin
      board.errors++;
      $display("%0t: %0d stats words never arrived", $time, board.pending_stats.size());
    end
    $display("Sent %0d samples over %0d register settings; %0d channel stats words checked.",
             board.accepted, settings_seen, board.checked);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/aclm_pkg.sv
hw/rtl/audio_channel_level_meter_core.sv
hw/rtl/aclm_checker.sv
verif/audio_channel_level_meter_core_tb.sv
